@@ rtl/lsp_pkg.sv @@
// Shared types and constants for the LRU slot pool.
`default_nettype none
package lsp_pkg;

	localparam int SLOTS = 8;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int ID_W = 16;
	localparam int STAMP_W = 64;
	localparam int SLOT_W = 3;
	localparam int FCNT_W = 4;
	localparam int IN_W = 24;
	localparam int OUT_W = 32;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_USE = 2'd1;
	localparam logic [1:0] OP_FREE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_OWNER = 2'd1;
	localparam logic [1:0] ST_REJECTED = 2'd2;

	// Accumulated findings of one pass over the slot store.
	typedef struct packed {
		logic own_hit;
		logic [IDX_W-1:0] own_idx;
		logic free_hit;
		logic [IDX_W-1:0] free_idx;
		logic [CNT_W-1:0] free_cnt;
		logic old_hit;
		logic [IDX_W-1:0] old_idx;
		logic [ID_W-1:0] old_owner;
	} lsp_scan_t;

endpackage
`default_nettype wire

@@ rtl/lru_slot_pool.sv @@
// Sequence: idle takes a request, scan steps through the slots, write-back updates the slot store and
// registers the result. A new request is taken only once the previous one is written back. The scan covers
// one slot per cycle through the shared compare unit; write-back waits while an unaccepted result holds the output.
// A finished result waits in the output register while the next request is taken.
// Reset (arst_n low, asynchronous) frees every slot, zeroes all stamps and the use counter.
`default_nettype none
module lru_slot_pool (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// opcode[1:0], consumer_id[17:2], zero pad [23:18]
	input wire logic [lsp_pkg::IN_W-1:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// status[1:0], slot_index[4:2], evicted[5], evicted_consumer[21:6],
	// newly_placed[22], free_count[26:23], zero pad [31:27]
	output logic [lsp_pkg::OUT_W-1:0] m_tdata
);
	import lsp_pkg::*;

	typedef enum logic [2:0] {
		SQ_IDLE = 3'b001,
		SQ_SCAN = 3'b010,
		SQ_WB = 3'b100
	} seq_t;

	seq_t state_q;
	logic [IDX_W-1:0] idx_q;
	logic [1:0] op_q;
	logic [ID_W-1:0] id_q;
	logic [ID_W-1:0] owner_q [SLOTS];
	logic [STAMP_W-1:0] stamp_q [SLOTS];
	logic [STAMP_W-1:0] counter_q;

	logic out_valid_q;
	logic [1:0] status_q;
	logic [SLOT_W-1:0] slot_q;
	logic ev_q;
	logic [ID_W-1:0] ev_id_q;
	logic placed_q;
	logic [FCNT_W-1:0] fc_q;

	lsp_scan_t scan;
	logic accept;
	logic out_free;
	logic wb_go;

	// Write-back decisions
	logic [1:0] n_status;
	logic [IDX_W-1:0] n_slot;
	logic n_ev;
	logic [ID_W-1:0] n_ev_id;
	logic n_placed;
	logic [CNT_W-1:0] n_fc;
	logic wr_en;
	logic [ID_W-1:0] wr_owner;
	logic [STAMP_W-1:0] wr_stamp;
	logic cnt_inc;
	logic [STAMP_W-1:0] cnt_next;

	assign s_tready = (state_q == SQ_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign wb_go = (state_q == SQ_WB) && out_free;
	assign cnt_next = counter_q + STAMP_W'(1);

	lsp_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.clear(accept),
		.step(state_q == SQ_SCAN),
		.idx(idx_q),
		.id(id_q),
		.owner(owner_q[idx_q]),
		.stamp(stamp_q[idx_q]),
		.res(scan)
	);

	always_comb begin
		n_status = ST_OK;
		n_slot = '0;
		n_ev = 1'b0;
		n_ev_id = '0;
		n_placed = 1'b0;
		n_fc = scan.free_cnt;
		wr_en = 1'b0;
		wr_owner = id_q;
		wr_stamp = counter_q;
		cnt_inc = 1'b0;
		if (id_q == '0) begin
			n_status = ST_REJECTED;
		end else begin
			case (op_q)
				OP_ALLOC: begin
					cnt_inc = 1'b1;
					wr_en = 1'b1;
					wr_stamp = cnt_next;
					if (scan.own_hit) begin
						n_slot = scan.own_idx;
					end else if (scan.free_hit) begin
						n_slot = scan.free_idx;
						n_placed = 1'b1;
						n_fc = scan.free_cnt - CNT_W'(1);
					end else begin
						n_slot = scan.old_idx;
						n_placed = 1'b1;
						n_ev = 1'b1;
						n_ev_id = scan.old_owner;
					end
				end
				OP_USE: begin
					if (scan.own_hit) begin
						n_slot = scan.own_idx;
						wr_en = 1'b1;
					end else begin
						n_status = ST_NOT_OWNER;
					end
				end
				OP_FREE: begin
					if (scan.own_hit) begin
						n_slot = scan.own_idx;
						wr_en = 1'b1;
						wr_owner = '0;
						wr_stamp = '0;
						n_fc = scan.free_cnt + CNT_W'(1);
					end else begin
						n_status = ST_NOT_OWNER;
					end
				end
				default: begin
					n_status = ST_REJECTED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			idx_q <= '0;
			counter_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				owner_q[i] <= '0;
				stamp_q[i] <= '0;
			end
		end else begin
			case (state_q)
				SQ_IDLE: begin
					if (accept) begin
						state_q <= SQ_SCAN;
						idx_q <= '0;
					end
				end
				SQ_SCAN: begin
					if (idx_q == IDX_W'(SLOTS - 1)) begin
						state_q <= SQ_WB;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				SQ_WB: begin
					if (out_free) begin
						state_q <= SQ_IDLE;
						if (wr_en) begin
							owner_q[n_slot] <= wr_owner;
							stamp_q[n_slot] <= wr_stamp;
						end
						if (cnt_inc) begin
							counter_q <= cnt_next;
						end
					end
				end
				default: begin
					state_q <= SQ_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= s_tdata[1:0];
			id_q <= s_tdata[17:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			status_q <= n_status;
			slot_q <= SLOT_W'(n_slot);
			ev_q <= n_ev;
			ev_id_q <= n_ev_id;
			placed_q <= n_placed;
			fc_q <= FCNT_W'(n_fc);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {5'b0, fc_q, placed_q, ev_id_q, ev_q, slot_q, status_q};

	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == SQ_SCAN && idx_q == '0))
		else $error("scan did not start at slot zero after a request");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status_q != ST_OK) |-> (slot_q == '0 && !ev_q && !placed_q))
		else $error("failed request reports a slot or placement");

	a_evict_places: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && ev_q) |-> (placed_q && ev_id_q != '0))
		else $error("eviction without placement or without a former owner");

	a_fc_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (fc_q <= FCNT_W'(SLOTS)))
		else $error("free count exceeds slot count");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_WB && out_valid_q && !m_tready) |=> (state_q == SQ_WB))
		else $error("write-back overran a waiting result");

endmodule
`default_nettype wire

@@ rtl/lsp_scan.sv @@
// Shared compare unit: examines one slot per cycle while step is high and accumulates the pass findings.
`default_nettype none
module lsp_scan (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic clear,
	input wire logic step,
	input wire logic [lsp_pkg::IDX_W-1:0] idx,
	input wire logic [lsp_pkg::ID_W-1:0] id,
	input wire logic [lsp_pkg::ID_W-1:0] owner,
	input wire logic [lsp_pkg::STAMP_W-1:0] stamp,
	output lsp_pkg::lsp_scan_t res
);
	import lsp_pkg::*;

	lsp_scan_t res_q;
	logic [STAMP_W-1:0] old_stamp_q;
	logic older;

	// Strictly smaller keeps the lowest index on ties.
	assign older = !res_q.old_hit || (stamp < old_stamp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
			old_stamp_q <= '0;
		end else if (clear) begin
			res_q.own_hit <= 1'b0;
			res_q.free_hit <= 1'b0;
			res_q.old_hit <= 1'b0;
			res_q.free_cnt <= '0;
		end else if (step) begin
			if (owner == id && !res_q.own_hit) begin
				res_q.own_hit <= 1'b1;
				res_q.own_idx <= idx;
			end
			if (owner == '0) begin
				res_q.free_cnt <= res_q.free_cnt + CNT_W'(1);
				if (!res_q.free_hit) begin
					res_q.free_hit <= 1'b1;
					res_q.free_idx <= idx;
				end
			end else if (older) begin
				res_q.old_hit <= 1'b1;
				res_q.old_idx <= idx;
				res_q.old_owner <= owner;
				old_stamp_q <= stamp;
			end
		end
	end

	assign res = res_q;

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Testbench for lru_slot_pool: directed table and random requests, checked against table rows or a slot-pool predictor.
`timescale 1ns / 100ps
module testbench;
	import lsp_pkg::*;

	localparam logic [1:0] OP_UNDEFINED = 2'd3;
	localparam int RANDOM_REQUESTS = 750;
	localparam int HOLD_AT_RESULT = 200;
	localparam int HOLD_CYCLES = 150;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] slot;
		logic evicted;
		logic [15:0] evicted_id;
		logic placed;
		logic [3:0] free_count;
	} pool_result_t;

	typedef struct packed {
		logic [1:0] op;
		logic [15:0] id;
		logic typed;
		pool_result_t want;
	} pool_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	logic [15:0] holder [SLOTS];
	logic [63:0] stamp [SLOTS];
	logic [63:0] use_count;

	pool_result_t pending_results [$];
	int mismatches = 0;
	int received = 0;

	// Rows with typed set carry an expectation readable straight from the pool rules.
	pool_row_t directed [25] = '{
		'{OP_FREE, 16'h1234, 1'b1, '{ST_NOT_OWNER, 3'd0, 1'b0, 16'h0000, 1'b0, 4'd8}},
		'{OP_USE, 16'h1234, 1'b1, '{ST_NOT_OWNER, 3'd0, 1'b0, 16'h0000, 1'b0, 4'd8}},
		'{OP_ALLOC, 16'h0000, 1'b1, '{ST_REJECTED, 3'd0, 1'b0, 16'h0000, 1'b0, 4'd8}},
		'{OP_USE, 16'h0000, 1'b1, '{ST_REJECTED, 3'd0, 1'b0, 16'h0000, 1'b0, 4'd8}},
		'{OP_FREE, 16'h0000, 1'b1, '{ST_REJECTED, 3'd0, 1'b0, 16'h0000, 1'b0, 4'd8}},
		'{OP_UNDEFINED, 16'h00FF, 1'b1, '{ST_REJECTED, 3'd0, 1'b0, 16'h0000, 1'b0, 4'd8}},
		'{OP_UNDEFINED, 16'h0000, 1'b1, '{ST_REJECTED, 3'd0, 1'b0, 16'h0000, 1'b0, 4'd8}},
		'{OP_ALLOC, 16'h0001, 1'b1, '{ST_OK, 3'd0, 1'b0, 16'h0000, 1'b1, 4'd7}},
		'{OP_ALLOC, 16'hFFFF, 1'b1, '{ST_OK, 3'd1, 1'b0, 16'h0000, 1'b1, 4'd6}},
		'{OP_ALLOC, 16'h0001, 1'b1, '{ST_OK, 3'd0, 1'b0, 16'h0000, 1'b0, 4'd6}},
		'{OP_USE, 16'hFFFF, 1'b1, '{ST_OK, 3'd1, 1'b0, 16'h0000, 1'b0, 4'd6}},
		'{OP_FREE, 16'h0001, 1'b1, '{ST_OK, 3'd0, 1'b0, 16'h0000, 1'b0, 4'd7}},
		'{OP_ALLOC, 16'hAAAA, 1'b1, '{ST_OK, 3'd0, 1'b0, 16'h0000, 1'b1, 4'd6}},
		'{OP_ALLOC, 16'h5555, 1'b1, '{ST_OK, 3'd2, 1'b0, 16'h0000, 1'b1, 4'd5}},
		'{OP_ALLOC, 16'h0002, 1'b0, '0},
		'{OP_ALLOC, 16'h0003, 1'b0, '0},
		'{OP_ALLOC, 16'h0004, 1'b0, '0},
		'{OP_ALLOC, 16'h0005, 1'b0, '0},
		'{OP_ALLOC, 16'h0006, 1'b0, '0},
		'{OP_USE, 16'h0003, 1'b0, '0},
		'{OP_ALLOC, 16'h0007, 1'b0, '0},
		'{OP_ALLOC, 16'h0008, 1'b0, '0},
		'{OP_FREE, 16'h0005, 1'b0, '0},
		'{OP_ALLOC, 16'h0009, 1'b0, '0},
		'{OP_FREE, 16'hFFFF, 1'b0, '0}
	};

	lru_slot_pool DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("lru_slot_pool: mismatch");
		$finish;
	end

	// Applies one request to the predicted pool and returns the result it produces.
	function automatic pool_result_t pool_apply(input logic [1:0] op, input logic [15:0] id);
		pool_result_t r;
		int hit;
		int k;
		int nfree;
		r = '0;
		hit = -1;
		nfree = 0;
		if (id == 16'h0000 || op == OP_UNDEFINED) begin
			r.status = ST_REJECTED;
		end else begin
			for (k = 0; k < SLOTS; k++)
				if (hit < 0 && holder[k] == id)
					hit = k;
			if (op == OP_ALLOC) begin
				use_count = use_count + 64'd1;
				if (hit < 0) begin
					for (k = 0; k < SLOTS; k++)
						if (hit < 0 && holder[k] == 16'h0000)
							hit = k;
					if (hit < 0) begin
						// Every slot is held: the oldest stamp loses, lowest index on ties.
						for (k = 0; k < SLOTS; k++)
							if (hit < 0 || stamp[k] < stamp[hit])
								hit = k;
						r.evicted = 1'b1;
						r.evicted_id = holder[hit];
					end
					holder[hit] = id;
					r.placed = 1'b1;
				end
				stamp[hit] = use_count;
				r.slot = 3'(hit);
			end else if (hit < 0) begin
				r.status = ST_NOT_OWNER;
			end else begin
				if (op == OP_USE) begin
					stamp[hit] = use_count;
				end else begin
					holder[hit] = 16'h0000;
					stamp[hit] = 64'd0;
				end
				r.slot = 3'(hit);
			end
		end
		for (k = 0; k < SLOTS; k++)
			if (holder[k] == 16'h0000)
				nfree++;
		r.free_count = 4'(nfree);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("ERROR at %0t: result %0d %s: got %0h, expected %0h",
			$realtime, received, what, got, want);
		mismatches++;
	endtask

	task automatic check_result(input logic [OUT_W-1:0] data);
		pool_result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("arrived with nothing pending", data, 64'd0);
		end else begin
			want = pending_results.pop_front();
			if (data[1:0] !== want.status)
				report_mismatch("status", data[1:0], want.status);
			if (data[4:2] !== want.slot)
				report_mismatch("slot_index", data[4:2], want.slot);
			if (data[5] !== want.evicted)
				report_mismatch("evicted", data[5], want.evicted);
			if (data[21:6] !== want.evicted_id)
				report_mismatch("evicted_consumer", data[21:6], want.evicted_id);
			if (data[22] !== want.placed)
				report_mismatch("newly_placed", data[22], want.placed);
			if (data[26:23] !== want.free_count)
				report_mismatch("free_count", data[26:23], want.free_count);
		end
	endtask

	// Offers one request after a gap, random or none, and records its expectation once accepted.
	task automatic send_request(input logic [1:0] op, input logic [15:0] id, input int seq,
			input logic typed, input pool_result_t want);
		int gap;
		pool_result_t predicted;
		gap = (seq % 150 < 40) ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, id, op};
		do @(posedge clk); while (!s_tready);
		predicted = pool_apply(op, id);
		pending_results.push_back(typed ? want : predicted);
	endtask

	initial begin
		int i;
		int roll;
		int span;
		logic [1:0] op;
		logic [15:0] id;
		for (i = 0; i < SLOTS; i++) begin
			holder[i] = 16'h0000;
			stamp[i] = 64'd0;
		end
		use_count = 64'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(directed); i++)
			send_request(directed[i].op, directed[i].id, i, directed[i].typed,
				directed[i].want);

		span = 10;
		for (i = 0; i < RANDOM_REQUESTS; i++) begin
			// Vary how many consumers compete for the eight slots.
			if (i % 100 == 0)
				span = $urandom_range(4, 14);
			roll = $urandom_range(0, 99);
			if (roll < 45)
				op = OP_ALLOC;
			else if (roll < 70)
				op = OP_USE;
			else if (roll < 93)
				op = OP_FREE;
			else
				op = OP_UNDEFINED;
			roll = $urandom_range(0, 99);
			if (roll < 4)
				id = 16'h0000;
			else if (roll < 12)
				id = 16'($urandom_range(1, 16'hFFFF));
			else
				id = 16'($urandom_range(1, span));
			send_request(op, id, i, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("lru_slot_pool: match");
		else
			$display("lru_slot_pool: mismatch");
		$finish;
	end

	initial begin
		int stall;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = (received % 170 < 40) ? 0 : $urandom_range(0, 6);
			// One long hold-off lets the block fill up and stop taking requests.
			if (received == HOLD_AT_RESULT)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			check_result(m_tdata);
			received++;
		end
	end

endmodule
